// File: hw/rtl/fcam_pkg.sv
package fcam_pkg;

    // fraction bits of the unit vectors
    localparam int VEC_FRAC_BITS = 14;
    localparam int VEC_ONE       = 1 << VEC_FRAC_BITS;

    // field and datapath widths
    localparam int W_VEC  = 16;
    localparam int W_POS  = 32;
    localparam int W_ANG  = 25;
    localparam int W_ASUM = 29;
    localparam int W_CRD  = 34;
    localparam int W_Z    = 27;
    localparam int W_MOP  = 33;
    localparam int W_PROD = 2 * W_MOP;
    localparam int W_NV   = 34;
    localparam int W_MAG  = 30;
    localparam int W_LEN  = 31;
    localparam int W_RAD  = 64;
    localparam int W_Q    = VEC_FRAC_BITS + 1;
    localparam int W_NUM  = W_MAG + VEC_FRAC_BITS + 2;

    // angle constants, degrees in Q9.16
    localparam int ANG_FULL    = 23592960;
    localparam int ANG_HALF    = 11796480;
    localparam int ANG_QUARTER = 5898240;
    localparam int PITCH_MAX   = 5832704;
    localparam int START_YAW   = -5898240;

    // rotation unit constants
    localparam int CORDIC_GAIN  = 652032874;
    localparam int CORDIC_STEPS = 17;

    typedef logic [2:0][W_VEC-1:0] t_vec;
    typedef logic [2:0][W_POS-1:0] t_pos;

    typedef enum logic {
        RD_SQRT,
        RD_DIV
    } t_rd_op;

    typedef struct packed {
        logic   start;
        t_rd_op op;
    } t_rd_req;

    // arctangent of 2^-i in degrees Q16
    function automatic logic signed [W_Z-1:0] atan_deg(input logic [4:0] i);
        logic signed [W_Z-1:0] v;
        unique case (i)
            5'd0:    v = W_Z'(2949120);
            5'd1:    v = W_Z'(1740967);
            5'd2:    v = W_Z'(919879);
            5'd3:    v = W_Z'(466945);
            5'd4:    v = W_Z'(234379);
            5'd5:    v = W_Z'(117304);
            5'd6:    v = W_Z'(58666);
            5'd7:    v = W_Z'(29335);
            5'd8:    v = W_Z'(14668);
            5'd9:    v = W_Z'(7334);
            5'd10:   v = W_Z'(3667);
            5'd11:   v = W_Z'(1833);
            5'd12:   v = W_Z'(917);
            5'd13:   v = W_Z'(458);
            5'd14:   v = W_Z'(229);
            5'd15:   v = W_Z'(115);
            5'd16:   v = W_Z'(57);
            default: v = '0;
        endcase
        return v;
    endfunction

    // next component index of a 3-vector, wrapping
    function automatic logic [1:0] next3(input logic [1:0] k);
        return (k == 2'd2) ? 2'd0 : k + 2'd1;
    endfunction

endpackage

// File: hw/rtl/fcam_mul.sv
module fcam_mul (
    input  logic                               i_clk,
    input  logic signed [fcam_pkg::W_MOP-1:0]  i_a,
    input  logic signed [fcam_pkg::W_MOP-1:0]  i_b,
    output logic signed [fcam_pkg::W_PROD-1:0] o_p
);
    import fcam_pkg::*;

    logic signed [W_PROD-1:0] r_p;

    // registered signed product
    always_ff @(posedge i_clk) begin
        r_p <= W_PROD'(i_a) * W_PROD'(i_b);
    end

    assign o_p = r_p;

endmodule

// File: hw/rtl/fcam_cordic.sv
module fcam_cordic (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic signed [fcam_pkg::W_ANG-1:0] i_angle,
    output logic                              o_busy,
    output logic                              o_done,
    output logic signed [fcam_pkg::W_CRD-1:0] o_cos,
    output logic signed [fcam_pkg::W_CRD-1:0] o_sin
);
    import fcam_pkg::*;

    localparam logic signed [W_Z-1:0] Z_QUARTER = W_Z'(ANG_QUARTER);
    localparam logic signed [W_Z-1:0] Z_HALF    = W_Z'(ANG_HALF);

    logic                    r_busy;
    logic                    r_done;
    logic                    r_neg;
    logic [4:0]              r_i;
    logic signed [W_CRD-1:0] r_x;
    logic signed [W_CRD-1:0] r_y;
    logic signed [W_Z-1:0]   r_z;

    logic signed [W_Z-1:0]   ang;
    logic signed [W_CRD-1:0] dx;
    logic signed [W_CRD-1:0] dy;

    assign ang = W_Z'(i_angle);
    assign dx  = r_y >>> r_i;
    assign dy  = r_x >>> r_i;

    // one micro-rotation per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start && !r_busy) begin
                r_busy <= 1'b1;
                r_i    <= '0;
                r_x    <= W_CRD'(CORDIC_GAIN);
                r_y    <= '0;
                // fold into the right half plane
                if (ang > Z_QUARTER) begin
                    r_z   <= ang - Z_HALF;
                    r_neg <= 1'b1;
                end else if (ang < -Z_QUARTER) begin
                    r_z   <= ang + Z_HALF;
                    r_neg <= 1'b1;
                end else begin
                    r_z   <= ang;
                    r_neg <= 1'b0;
                end
            end else if (r_busy) begin
                if (r_z >= 0) begin
                    r_x <= r_x - dx;
                    r_y <= r_y + dy;
                    r_z <= r_z - atan_deg(r_i);
                end else begin
                    r_x <= r_x + dx;
                    r_y <= r_y - dy;
                    r_z <= r_z + atan_deg(r_i);
                end
                r_i <= r_i + 5'd1;
                if (r_i == 5'(CORDIC_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_cos  = r_neg ? -r_x : r_x;
    assign o_sin  = r_neg ? -r_y : r_y;

endmodule

// File: hw/rtl/fcam_rootdiv.sv
module fcam_rootdiv (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  fcam_pkg::t_rd_req           i_req,
    input  logic [fcam_pkg::W_RAD-1:0]  i_rad,
    input  logic [fcam_pkg::W_NUM-1:0]  i_num,
    input  logic [fcam_pkg::W_LEN:0]    i_den,
    output logic                        o_busy,
    output logic                        o_done,
    output logic [31:0]                 o_res
);
    import fcam_pkg::*;

    logic              r_busy;
    logic              r_done;
    t_rd_op            r_op;
    logic [4:0]        r_k;
    logic [W_RAD-1:0]  r_v;
    logic [W_RAD-1:0]  r_r;
    logic [W_NUM-1:0]  r_rem;
    logic [W_NUM-1:0]  r_dsh;
    logic [W_Q-1:0]    r_q;

    logic [W_RAD-1:0]  bitv;
    logic [W_RAD-1:0]  trial;

    assign bitv  = W_RAD'(1) << {r_k, 1'b0};
    assign trial = r_r + bitv;

    // digit-by-digit square root, or restoring divide, one bit per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start && !r_busy) begin
                r_busy <= 1'b1;
                r_op   <= i_req.op;
                r_v    <= i_rad;
                r_r    <= '0;
                r_rem  <= i_num;
                r_dsh  <= W_NUM'(i_den) << VEC_FRAC_BITS;
                r_q    <= '0;
                r_k    <= (i_req.op == RD_SQRT) ? 5'd31 : 5'(VEC_FRAC_BITS);
            end else if (r_busy) begin
                if (r_op == RD_SQRT) begin
                    if (r_v >= trial) begin
                        r_v <= r_v - trial;
                        r_r <= (r_r >> 1) + bitv;
                    end else begin
                        r_r <= r_r >> 1;
                    end
                end else begin
                    if (r_rem >= r_dsh) begin
                        r_rem <= r_rem - r_dsh;
                        r_q   <= {r_q[W_Q-2:0], 1'b1};
                    end else begin
                        r_q   <= {r_q[W_Q-2:0], 1'b0};
                    end
                    r_dsh <= r_dsh >> 1;
                end
                r_k <= r_k - 5'd1;
                if (r_k == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_res  = (r_op == RD_SQRT) ? r_r[31:0] : 32'(r_q);

endmodule

// File: hw/rtl/fly_camera_orientation_update_top.sv
// channel  | valid        | stall        | payload
// ---------+--------------+--------------+---------------------------------------------
// input    | i_in_valid   | o_in_stall   | i_opcode i_direction i_delta_time i_x/y_offset
// output   | o_out_valid  | i_out_stall  | o_pos_* o_front_* o_right_* o_up_*
// config   | psel penable | pready (=1)  | paddr pwrite pwdata prdata
//
// A move passes the velocity product and the position updates on its way to the output
// register. A look runs the angle wrap steps and two 17-step rotations, then three
// normalizations, each of 32 square-root steps and three 15-step divides, and two cross
// products, all sharing one multiplier, one rotation unit and one root/divide unit under
// the sequencer below.
// After reset the vectors are rebuilt from the start angles with o_in_stall high. A
// finished beat waits in the output register; a new item is taken while it waits, and
// the next result holds in the sequencer until the beat is taken.
module fly_camera_orientation_update_top (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // input channel
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic                i_opcode,
    input  logic [2:0]          i_direction,
    input  logic [15:0]         i_delta_time,
    input  logic signed [15:0]  i_x_offset,
    input  logic signed [15:0]  i_y_offset,
    // output channel
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic signed [31:0]  o_pos_x,
    output logic signed [31:0]  o_pos_y,
    output logic signed [31:0]  o_pos_z,
    output logic signed [15:0]  o_front_x,
    output logic signed [15:0]  o_front_y,
    output logic signed [15:0]  o_front_z,
    output logic signed [15:0]  o_right_x,
    output logic signed [15:0]  o_right_y,
    output logic signed [15:0]  o_right_z,
    output logic signed [15:0]  o_up_x,
    output logic signed [15:0]  o_up_y,
    output logic signed [15:0]  o_up_z,
    // configuration port
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [4:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);
    import fcam_pkg::*;

    typedef enum logic [2:0] {
        REG_SPEED,
        REG_SENS,
        REG_LIMIT,
        REG_WU_X,
        REG_WU_Y,
        REG_WU_Z,
        REG_START_YAW,
        REG_START_PITCH
    } t_reg_idx;

    typedef enum logic [1:0] {
        T_FRONT,
        T_RIGHT,
        T_UP
    } t_tgt;

    typedef enum logic [4:0] {
        S_IDLE,
        S_M_VEL,
        S_M_VWAIT,
        S_M_DISP,
        S_M_ADD,
        S_L_DX,
        S_L_DY,
        S_L_PY,
        S_L_WRAP,
        S_R_YAW,
        S_R_YAWW,
        S_R_PITW,
        S_R_F0,
        S_R_F2,
        S_R_F2W,
        S_N_START,
        S_N_SQ,
        S_N_ACC,
        S_N_SQRT,
        S_N_SQW,
        S_N_DIV,
        S_N_DIVW,
        S_N_DONE,
        S_X_M1,
        S_X_M2,
        S_X_SUB,
        S_FINISH
    } t_state;

    localparam logic signed [W_ASUM-1:0] A_HALF = W_ASUM'(ANG_HALF);
    localparam logic signed [W_ASUM-1:0] A_FULL = W_ASUM'(ANG_FULL);
    localparam logic signed [W_ASUM-1:0] P_MAX  = W_ASUM'(PITCH_MAX);
    localparam logic signed [W_PROD-1:0] RND30  = W_PROD'(64'sd1 <<< 29);
    localparam logic signed [W_PROD-1:0] RND4   = W_PROD'(64'sd8);
    localparam logic signed [W_PROD-1:0] RND_V  = W_PROD'(64'sd1 <<< (VEC_FRAC_BITS + 7));
    localparam logic signed [W_PROD-1:0] RND_W  = W_PROD'(64'sd1 <<< 21);
    localparam logic signed [34:0]       POS_MAX = 35'sh07FFFFFFF;
    localparam logic signed [34:0]       POS_MIN = -35'sh080000000;
    localparam logic [W_Q-1:0]           Q_ONE   = W_Q'(VEC_ONE);

    // configuration registers
    logic [15:0]           r_speed;
    logic [15:0]           r_sens;
    logic                  r_limit;
    t_vec                  r_wu;
    logic [W_ANG-1:0]      r_syaw;
    logic [W_ANG-1:0]      r_spitch;

    // camera state and sequencer registers
    t_state                  r_state;
    logic                    r_init;
    t_tgt                    r_tgt;
    logic [1:0]              r_idx;
    t_pos                    r_pos;
    logic signed [W_ANG-1:0] r_yaw;
    logic signed [W_ANG-1:0] r_pitch;
    t_vec                    r_front;
    t_vec                    r_right;
    t_vec                    r_up;
    logic [2:0]              r_dir;
    logic [15:0]             r_dt;
    logic signed [15:0]      r_xo;
    logic signed [15:0]      r_yo;
    logic [31:0]             r_vel;
    logic signed [W_ASUM-1:0] r_ysum;
    logic signed [W_ASUM-1:0] r_psum;
    logic signed [W_CRD-1:0] r_cy;
    logic signed [W_CRD-1:0] r_sy;
    logic signed [W_CRD-1:0] r_cp;
    logic signed [W_CRD-1:0] r_sp;
    logic [2:0][W_NV-1:0]    r_vec;
    logic [2:0][W_MAG-1:0]   r_mag;
    logic [W_RAD-1:0]        r_acc;
    logic [W_LEN-1:0]        r_len;
    logic signed [W_NV-1:0]  r_t1;
    logic                    r_ovalid;
    t_pos                    r_opos;
    t_vec                    r_ofront;
    t_vec                    r_oright;
    t_vec                    r_oup;

    // shared units
    logic signed [W_MOP-1:0]  mul_a;
    logic signed [W_MOP-1:0]  mul_b;
    logic signed [W_PROD-1:0] mul_p;
    logic                     crd_start;
    logic                     crd_busy;
    logic                     crd_done;
    logic signed [W_CRD-1:0]  crd_cos;
    logic signed [W_CRD-1:0]  crd_sin;
    t_rd_req                  rd_req;
    logic                     rd_busy;
    logic                     rd_done;
    logic [31:0]              rd_res;
    logic [W_NUM-1:0]         rd_num;

    logic       in_acc;
    logic       cfg_wr;
    t_reg_idx   cfg_idx;

    fcam_mul u_mul (
        .i_clk (i_clk),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (mul_p)
    );

    fcam_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (crd_start),
        .i_angle ((r_state == S_R_YAW) ? r_yaw : r_pitch),
        .o_busy  (crd_busy),
        .o_done  (crd_done),
        .o_cos   (crd_cos),
        .o_sin   (crd_sin)
    );

    fcam_rootdiv u_rootdiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (rd_req),
        .i_rad   (r_acc),
        .i_num   (rd_num),
        .i_den   ({r_len, 1'b0}),
        .o_busy  (rd_busy),
        .o_done  (rd_done),
        .o_res   (rd_res)
    );

    assign in_acc     = i_in_valid && !o_in_stall;
    assign o_in_stall = (r_state != S_IDLE);
    assign cfg_wr     = psel && penable && pwrite;
    assign cfg_idx    = t_reg_idx'(paddr[4:2]);
    assign pready     = 1'b1;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_speed  <= 16'd640;
            r_sens   <= 16'd6554;
            r_limit  <= 1'b1;
            r_wu     <= {16'd0, 16'd16384, 16'd0};
            r_syaw   <= W_ANG'(START_YAW);
            r_spitch <= '0;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                REG_SPEED:       r_speed    <= pwdata[15:0];
                REG_SENS:        r_sens     <= pwdata[15:0];
                REG_LIMIT:       r_limit    <= pwdata[0];
                REG_WU_X:        r_wu[0]    <= pwdata[15:0];
                REG_WU_Y:        r_wu[1]    <= pwdata[15:0];
                REG_WU_Z:        r_wu[2]    <= pwdata[15:0];
                REG_START_YAW:   r_syaw     <= pwdata[W_ANG-1:0];
                REG_START_PITCH: r_spitch   <= pwdata[W_ANG-1:0];
            endcase
        end
    end

    // register read-back
    always_comb begin
        unique case (cfg_idx)
            REG_SPEED:       prdata = {16'd0, r_speed};
            REG_SENS:        prdata = {16'd0, r_sens};
            REG_LIMIT:       prdata = {31'd0, r_limit};
            REG_WU_X:        prdata = {{16{r_wu[0][15]}}, r_wu[0]};
            REG_WU_Y:        prdata = {{16{r_wu[1][15]}}, r_wu[1]};
            REG_WU_Z:        prdata = {{16{r_wu[2][15]}}, r_wu[2]};
            REG_START_YAW:   prdata = {{(32-W_ANG){r_syaw[W_ANG-1]}}, r_syaw};
            REG_START_PITCH: prdata = {{(32-W_ANG){r_spitch[W_ANG-1]}}, r_spitch};
        endcase
    end

    // cross product operands and component order
    t_vec       xa;
    t_vec       xb;
    logic [1:0] i1;
    logic [1:0] i2;
    logic [W_VEC-1:0] mv;

    assign xa = (r_tgt == T_RIGHT) ? r_front : r_right;
    assign xb = (r_tgt == T_RIGHT) ? r_wu : r_front;
    assign i1 = next3(r_idx);
    assign i2 = next3(i1);
    assign mv = (r_dir < 3'd2) ? r_front[r_idx] :
                (r_dir < 3'd4) ? r_right[r_idx] : r_wu[r_idx];

    // multiplier operand select
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (r_state)
            S_M_VEL: begin
                mul_a = W_MOP'(r_speed);
                mul_b = W_MOP'(r_dt);
            end
            S_M_DISP: begin
                mul_a = {{(W_MOP-W_VEC){mv[W_VEC-1]}}, mv};
                mul_b = W_MOP'(r_vel);
            end
            S_L_DX: begin
                mul_a = W_MOP'(r_xo);
                mul_b = W_MOP'(r_sens);
            end
            S_L_DY: begin
                mul_a = W_MOP'(r_yo);
                mul_b = W_MOP'(r_sens);
            end
            S_R_F0: begin
                mul_a = r_cy[W_MOP-1:0];
                mul_b = r_cp[W_MOP-1:0];
            end
            S_R_F2: begin
                mul_a = r_sy[W_MOP-1:0];
                mul_b = r_cp[W_MOP-1:0];
            end
            S_N_SQ: begin
                mul_a = W_MOP'(r_mag[r_idx]);
                mul_b = W_MOP'(r_mag[r_idx]);
            end
            S_X_M1: begin
                mul_a = {{(W_MOP-W_VEC){xa[i1][W_VEC-1]}}, xa[i1]};
                mul_b = {{(W_MOP-W_VEC){xb[i2][W_VEC-1]}}, xb[i2]};
            end
            S_X_M2: begin
                mul_a = {{(W_MOP-W_VEC){xa[i2][W_VEC-1]}}, xa[i2]};
                mul_b = {{(W_MOP-W_VEC){xb[i1][W_VEC-1]}}, xb[i1]};
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // magnitudes and pre-shift for normalization
    logic [2:0][W_NV-1:0]  absv;
    logic [W_NV-1:0]       maxm;
    logic [2:0]            nshift;
    logic [2:0][W_MAG-1:0] smag;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            absv[k] = r_vec[k][W_NV-1] ? W_NV'(-r_vec[k]) : r_vec[k];
        end
        maxm = absv[0];
        if (absv[1] > maxm) maxm = absv[1];
        if (absv[2] > maxm) maxm = absv[2];
        priority if (maxm[33]) nshift = 3'd4;
        else if (maxm[32])     nshift = 3'd3;
        else if (maxm[31])     nshift = 3'd2;
        else if (maxm[30])     nshift = 3'd1;
        else                   nshift = 3'd0;
        for (int k = 0; k < 3; k++) begin
            smag[k] = W_MAG'(absv[k] >> nshift);
        end
    end

    assign rd_num = (W_NUM'(r_mag[r_idx]) << (VEC_FRAC_BITS + 1)) + W_NUM'(r_len);

    // quotient to signed component
    logic [W_Q-1:0]   qc;
    logic [W_VEC-1:0] qv;
    assign qc = (rd_res[W_Q-1:0] > Q_ONE) ? Q_ONE : rd_res[W_Q-1:0];
    assign qv = r_vec[r_idx][W_NV-1] ? W_VEC'(-W_VEC'(qc)) : W_VEC'(qc);

    // move displacement and saturating add
    logic signed [W_PROD-1:0] dsp_v;
    logic signed [W_PROD-1:0] dsp_w;
    logic signed [34:0]       dsp;
    logic signed [34:0]       pos_old;
    logic signed [34:0]       pos_sum;
    logic [W_POS-1:0]         pos_new;

    assign dsp_v   = (mul_p + RND_V) >>> (VEC_FRAC_BITS + 8);
    assign dsp_w   = (mul_p + RND_W) >>> 22;
    assign dsp     = (r_dir >= 3'd4) ? dsp_w[34:0] : dsp_v[34:0];
    assign pos_old = 35'($signed(r_pos[r_idx]));
    assign pos_sum = r_dir[0] ? pos_old - dsp : pos_old + dsp;
    assign pos_new = (pos_sum > POS_MAX) ? W_POS'(POS_MAX) :
                     (pos_sum < POS_MIN) ? W_POS'(POS_MIN) : pos_sum[W_POS-1:0];

    // angle increments and wrapping
    logic signed [W_PROD-1:0] rnd4;
    logic signed [W_PROD-1:0] rnd30;
    logic                     yaw_ok;
    logic                     pit_ok;
    logic signed [W_ASUM-1:0] p_clamp;

    assign rnd4    = (mul_p + RND4) >>> 4;
    assign rnd30   = (mul_p + RND30) >>> 30;
    assign yaw_ok  = (r_ysum >= -A_HALF) && (r_ysum < A_HALF);
    assign pit_ok  = r_limit || ((r_psum >= -A_HALF) && (r_psum < A_HALF));
    assign p_clamp = (r_psum > P_MAX) ? P_MAX : (r_psum < -P_MAX) ? -P_MAX : r_psum;

    assign crd_start    = (r_state == S_R_YAW) || (r_state == S_R_YAWW && crd_done);
    assign rd_req.start = (r_state == S_N_SQRT) || (r_state == S_N_DIV);
    assign rd_req.op    = (r_state == S_N_SQRT) ? RD_SQRT : RD_DIV;

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_R_YAW;
            r_init   <= 1'b1;
            r_tgt    <= T_FRONT;
            r_idx    <= '0;
            r_ovalid <= 1'b0;
            r_pos    <= '0;
            r_yaw    <= W_ANG'(START_YAW);
            r_pitch  <= '0;
        end else begin
            // beat taken and no new one loaded this cycle
            if (r_ovalid && !i_out_stall && r_state != S_FINISH) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_dir <= i_direction;
                        r_dt  <= i_delta_time;
                        r_xo  <= i_x_offset;
                        r_yo  <= i_y_offset;
                        r_idx <= '0;
                        r_state <= i_opcode ? S_L_DX : S_M_VEL;
                    end
                end
                // keyboard move
                S_M_VEL: r_state <= S_M_VWAIT;
                S_M_VWAIT: begin
                    r_vel   <= mul_p[31:0];
                    r_state <= (r_dir > 3'd5) ? S_FINISH : S_M_DISP;
                end
                S_M_DISP: r_state <= S_M_ADD;
                S_M_ADD: begin
                    r_pos[r_idx] <= pos_new;
                    r_idx        <= r_idx + 2'd1;
                    r_state      <= (r_idx == 2'd2) ? S_FINISH : S_M_DISP;
                end
                // mouse look
                S_L_DX: r_state <= S_L_DY;
                S_L_DY: begin
                    r_ysum  <= W_ASUM'(r_yaw) + rnd4[W_ASUM-1:0];
                    r_state <= S_L_PY;
                end
                S_L_PY: begin
                    r_psum  <= W_ASUM'(r_pitch) + rnd4[W_ASUM-1:0];
                    r_state <= S_L_WRAP;
                end
                S_L_WRAP: begin
                    if (yaw_ok && pit_ok) begin
                        r_yaw   <= r_ysum[W_ANG-1:0];
                        r_pitch <= r_limit ? p_clamp[W_ANG-1:0] : r_psum[W_ANG-1:0];
                        r_state <= S_R_YAW;
                    end else begin
                        if (!yaw_ok) begin
                            r_ysum <= (r_ysum < 0) ? r_ysum + A_FULL : r_ysum - A_FULL;
                        end
                        if (!pit_ok) begin
                            r_psum <= (r_psum < 0) ? r_psum + A_FULL : r_psum - A_FULL;
                        end
                    end
                end
                // rebuild front from the angles
                S_R_YAW: r_state <= S_R_YAWW;
                S_R_YAWW: begin
                    if (crd_done) begin
                        r_cy    <= crd_cos;
                        r_sy    <= crd_sin;
                        r_state <= S_R_PITW;
                    end
                end
                S_R_PITW: begin
                    if (crd_done) begin
                        r_cp    <= crd_cos;
                        r_sp    <= crd_sin;
                        r_state <= S_R_F0;
                    end
                end
                S_R_F0: r_state <= S_R_F2;
                S_R_F2: begin
                    r_vec[0] <= rnd30[W_NV-1:0];
                    r_state  <= S_R_F2W;
                end
                S_R_F2W: begin
                    r_vec[2] <= rnd30[W_NV-1:0];
                    r_vec[1] <= W_NV'(r_sp);
                    r_tgt    <= T_FRONT;
                    r_state  <= S_N_START;
                end
                // normalize r_vec into the target vector
                S_N_START: begin
                    r_mag   <= smag;
                    r_acc   <= '0;
                    r_idx   <= '0;
                    r_state <= S_N_SQ;
                end
                S_N_SQ: r_state <= S_N_ACC;
                S_N_ACC: begin
                    r_acc   <= r_acc + mul_p[W_RAD-1:0];
                    r_idx   <= (r_idx == 2'd2) ? 2'd0 : r_idx + 2'd1;
                    r_state <= (r_idx == 2'd2) ? S_N_SQRT : S_N_SQ;
                end
                S_N_SQRT: r_state <= S_N_SQW;
                S_N_SQW: begin
                    if (rd_done) begin
                        r_len <= rd_res[W_LEN-1:0];
                        if (rd_res == '0) begin
                            // degenerate vector
                            unique case (r_tgt)
                                T_FRONT: r_front <= '0;
                                T_RIGHT: r_right <= '0;
                                T_UP:    r_up    <= '0;
                            endcase
                            r_state <= S_N_DONE;
                        end else begin
                            r_state <= S_N_DIV;
                        end
                    end
                end
                S_N_DIV: r_state <= S_N_DIVW;
                S_N_DIVW: begin
                    if (rd_done) begin
                        unique case (r_tgt)
                            T_FRONT: r_front[r_idx] <= qv;
                            T_RIGHT: r_right[r_idx] <= qv;
                            T_UP:    r_up[r_idx]    <= qv;
                        endcase
                        r_idx   <= (r_idx == 2'd2) ? 2'd0 : r_idx + 2'd1;
                        r_state <= (r_idx == 2'd2) ? S_N_DONE : S_N_DIV;
                    end
                end
                S_N_DONE: begin
                    r_idx <= '0;
                    unique case (r_tgt)
                        T_FRONT: begin
                            r_tgt   <= T_RIGHT;
                            r_state <= S_X_M1;
                        end
                        T_RIGHT: begin
                            r_tgt   <= T_UP;
                            r_state <= S_X_M1;
                        end
                        T_UP: begin
                            r_init  <= 1'b0;
                            r_state <= r_init ? S_IDLE : S_FINISH;
                        end
                    endcase
                end
                // cross product into r_vec, two products per component
                S_X_M1: r_state <= S_X_M2;
                S_X_M2: begin
                    r_t1    <= mul_p[W_NV-1:0];
                    r_state <= S_X_SUB;
                end
                S_X_SUB: begin
                    r_vec[r_idx] <= r_t1 - mul_p[W_NV-1:0];
                    r_idx        <= (r_idx == 2'd2) ? 2'd0 : r_idx + 2'd1;
                    r_state      <= (r_idx == 2'd2) ? S_N_START : S_X_M1;
                end
                // hand the state over to the output register
                S_FINISH: begin
                    if (!r_ovalid || !i_out_stall) begin
                        r_ovalid <= 1'b1;
                        r_opos   <= r_pos;
                        r_ofront <= r_front;
                        r_oright <= r_right;
                        r_oup    <= r_up;
                        r_state  <= S_IDLE;
                    end
                end
            endcase
        end
    end

    assign o_out_valid = r_ovalid;
    assign o_pos_x     = r_opos[0];
    assign o_pos_y     = r_opos[1];
    assign o_pos_z     = r_opos[2];
    assign o_front_x   = r_ofront[0];
    assign o_front_y   = r_ofront[1];
    assign o_front_z   = r_ofront[2];
    assign o_right_x   = r_oright[0];
    assign o_right_y   = r_oright[1];
    assign o_right_z   = r_oright[2];
    assign o_up_x      = r_oup[0];
    assign o_up_y      = r_oup[1];
    assign o_up_z      = r_oup[2];

    // checks
    localparam logic signed [W_VEC-1:0] V_ONE = W_VEC'(VEC_ONE);

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> o_in_stall)
        else $error("input taken while sequencer idle");

    a_front_unit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_front_x <= V_ONE && o_front_x >= -V_ONE &&
                         o_front_y <= V_ONE && o_front_y >= -V_ONE))
        else $error("front component beyond unit length");

    a_rd_start_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rd_req.start |-> !rd_busy)
        else $error("root/divide unit started while busy");

    a_crd_start_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        crd_start |-> !crd_busy)
        else $error("rotation unit started while busy");

    a_beat_from_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ovalid) |-> $past(r_state == S_FINISH))
        else $error("output beat not from finish state");

endmodule
